// ----- sv/servo_pwm_update_coalescer_top_defines.svh -----
// Assertion macros shared by the coalescer checker.
`ifndef SERVO_PWM_UPDATE_COALESCER_TOP_DEFINES_SVH
`define SERVO_PWM_UPDATE_COALESCER_TOP_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define SPUC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked assertion that also holds through reset.
`define SPUC_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/spuc_pkg.sv -----
// Package of the servo PWM update coalescer: constants, state and command types.
`timescale 1ns / 1ps

package spuc_pkg;

   localparam int unsigned CHANNELS_DEF    = 16;
   localparam int unsigned GROUPS_DEF      = 4;

   localparam int unsigned COUNT_W         = 12;
   localparam int unsigned PULSE_W         = 16;
   localparam int unsigned CHAN_FIELD_W    = 5;
   localparam int unsigned GROUP_W         = 2;
   localparam int unsigned OUT_CHAN_W      = 4;
   localparam int unsigned ADDR_W          = 7;
   localparam int unsigned REQ_TDATA_W     = 24;
   localparam int unsigned RSP_TDATA_W     = 24;

   localparam int unsigned OFF_REG_BASE    = 8;
   localparam int unsigned COUNT_MAX       = 4095;
   localparam int unsigned THRESHOLD_RESET = 5;

   // count = floor(pulse * 768 / 3125), done as a multiply by a rounded-up
   // reciprocal; with a 26-bit shift it is exact for every unsaturated pulse.
   localparam int unsigned US_TO_COUNT_NUM = 768;
   localparam int unsigned US_TO_COUNT_DEN = 3125;
   localparam int unsigned RECIP_SHIFT     = 26;
   localparam int unsigned RECIP_W         = 24;
   localparam longint unsigned RECIP_MULT_L =
      ((64'(US_TO_COUNT_NUM) << RECIP_SHIFT) + 64'(US_TO_COUNT_DEN) - 64'd1)
      / 64'(US_TO_COUNT_DEN);
   localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(RECIP_MULT_L);
   // Smallest pulse whose count reaches COUNT_MAX + 1.
   localparam int unsigned SAT_PULSE =
      ((COUNT_MAX + 1) * US_TO_COUNT_DEN + US_TO_COUNT_NUM - 1) / US_TO_COUNT_NUM;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_CHECK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic capture;     // take the accepted item into the item registers
      logic set_write;   // store the converted count as desired value
      logic sync_start;  // load the scan index with the group
      logic rd_en;       // read both stores at the scan index
      logic commit;      // copy desired into written, park the write in hold
      logic advance;     // step the scan index by the group stride
      logic push;        // move the parked write into the output register
      logic push_last;   // the pushed write closes the sync item
   } cmd_type;

   typedef struct packed {
      logic item_sync;   // captured item is a sync
      logic group_ok;    // group names at least one channel
      logic hit;         // channel at scan index is over threshold
      logic at_end;      // scan index is on the last member of the group
      logic hold_valid;  // a write is parked
      logic slot_free;   // output register can load this cycle
   } status_type;

endpackage

// ----- sv/spuc_ctrl.sv -----
// Controller state machine of the coalescer: sequences set and sync items.
`timescale 1ns / 1ps

module spuc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  spuc_pkg::status_type status,
   output spuc_pkg::cmd_type    cmd
);

   spuc_pkg::state_type state_ff;
   spuc_pkg::state_type state_in;
   logic                stall;

   // Scan has to wait when a new hit would overwrite a parked write
   // that the output register cannot take yet.
   assign stall = status.hit && status.hold_valid && !status.slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spuc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spuc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = spuc_pkg::ST_DECODE;
            end
         end
         spuc_pkg::ST_DECODE: begin
            if (status.item_sync && status.group_ok) begin
               state_in = spuc_pkg::ST_READ;
            end else begin
               state_in = spuc_pkg::ST_IDLE;
            end
         end
         spuc_pkg::ST_READ: begin
            state_in = spuc_pkg::ST_CHECK;
         end
         spuc_pkg::ST_CHECK: begin
            if (!stall) begin
               state_in = status.at_end ? spuc_pkg::ST_FLUSH : spuc_pkg::ST_READ;
            end
         end
         spuc_pkg::ST_FLUSH: begin
            if (!status.hold_valid || status.slot_free) begin
               state_in = spuc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spuc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         spuc_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         spuc_pkg::ST_DECODE: begin
            cmd.set_write  = !status.item_sync;
            cmd.sync_start = status.item_sync && status.group_ok;
         end
         spuc_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
         end
         spuc_pkg::ST_CHECK: begin
            if (!stall) begin
               cmd.commit  = status.hit;
               cmd.push    = status.hit && status.hold_valid;
               cmd.advance = 1'b1;
            end
         end
         spuc_pkg::ST_FLUSH: begin
            cmd.push      = status.hold_valid && status.slot_free;
            cmd.push_last = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- sv/spuc_datapath.sv -----
// Datapath of the coalescer: count stores, conversion, compare, hold and output register.
`timescale 1ns / 1ps

module spuc_datapath #(
   parameter int unsigned CHANNELS = spuc_pkg::CHANNELS_DEF,
   parameter int unsigned GROUPS   = spuc_pkg::GROUPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_mode,
   input  logic [spuc_pkg::CHAN_FIELD_W-1:0]     req_channel,
   input  logic [spuc_pkg::PULSE_W-1:0]          req_pulse_us,
   input  logic [spuc_pkg::GROUP_W-1:0]          req_group,
   input  logic                                  csr_we,
   input  logic [spuc_pkg::COUNT_W-1:0]          csr_wdata,
   input  spuc_pkg::cmd_type                     cmd,
   output spuc_pkg::status_type                  status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [spuc_pkg::OUT_CHAN_W-1:0]       rsp_out_channel,
   output logic [spuc_pkg::ADDR_W-1:0]           rsp_reg_address,
   output logic [spuc_pkg::COUNT_W-1:0]          rsp_off_count,
   output logic                                  rsp_last
);

   localparam int unsigned CH_W  = $clog2(CHANNELS);
   localparam int unsigned IDX_W = $clog2(CHANNELS + GROUPS);
   localparam int unsigned CNT_W = spuc_pkg::COUNT_W;
   localparam int unsigned PRD_W = spuc_pkg::PULSE_W + spuc_pkg::RECIP_W;

   // Captured item
   logic                              item_mode_ff,  item_mode_in;
   logic [spuc_pkg::CHAN_FIELD_W-1:0] item_chan_ff,  item_chan_in;
   logic [spuc_pkg::PULSE_W-1:0]      item_pulse_ff, item_pulse_in;
   logic [spuc_pkg::GROUP_W-1:0]      item_group_ff, item_group_in;

   logic [CNT_W-1:0] thr_ff, thr_in;

   // Count stores with per-entry valid bits; an unwritten entry reads as zero.
   logic [CNT_W-1:0]    desired_mem_ff [CHANNELS];
   logic [CNT_W-1:0]    written_mem_ff [CHANNELS];
   logic [CHANNELS-1:0] desired_vld_ff, desired_vld_in;
   logic [CHANNELS-1:0] written_vld_ff, written_vld_in;
   logic [CNT_W-1:0]    rd_desired_ff;
   logic [CNT_W-1:0]    rd_written_ff;
   logic                rd_dvld_ff;
   logic                rd_wvld_ff;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] next_idx;
   logic [CH_W-1:0]  rd_idx;
   logic [CH_W-1:0]  set_idx;
   logic             set_ok;

   logic [PRD_W-1:0] conv_prod;
   logic [CNT_W-1:0] conv_count;

   logic [CNT_W-1:0] cur_desired;
   logic [CNT_W-1:0] cur_written;
   logic [CNT_W:0]   diff;

   logic             hold_vld_ff, hold_vld_in;
   logic [CH_W-1:0]  hold_idx_ff, hold_idx_in;
   logic [CNT_W-1:0] hold_count_ff, hold_count_in;

   logic                            rsp_vld_ff,   rsp_vld_in;
   logic [spuc_pkg::OUT_CHAN_W-1:0] rsp_chan_ff,  rsp_chan_in;
   logic [spuc_pkg::ADDR_W-1:0]     rsp_addr_ff,  rsp_addr_in;
   logic [CNT_W-1:0]                rsp_count_ff, rsp_count_in;
   logic                            rsp_last_ff,  rsp_last_in;

   assign set_idx  = CH_W'(item_chan_ff);
   assign set_ok   = item_chan_ff < CHANNELS;
   assign rd_idx   = idx_ff[CH_W-1:0];
   assign next_idx = idx_ff + IDX_W'(GROUPS);

   // Pulse to count: reciprocal multiply, then saturate.
   assign conv_prod  = PRD_W'(item_pulse_ff) * PRD_W'(spuc_pkg::RECIP_MULT);
   assign conv_count = (item_pulse_ff >= spuc_pkg::PULSE_W'(spuc_pkg::SAT_PULSE))
                       ? CNT_W'(spuc_pkg::COUNT_MAX)
                       : conv_prod[spuc_pkg::RECIP_SHIFT +: CNT_W];

   assign cur_desired = rd_dvld_ff ? rd_desired_ff : '0;
   assign cur_written = rd_wvld_ff ? rd_written_ff : '0;
   assign diff = (cur_desired >= cur_written)
                 ? {1'b0, cur_desired} - {1'b0, cur_written}
                 : {1'b0, cur_written} - {1'b0, cur_desired};

   assign status.item_sync  = item_mode_ff;
   assign status.group_ok   = (item_group_ff < GROUPS) && (item_group_ff < CHANNELS);
   assign status.hit        = diff > {1'b0, thr_ff};
   assign status.at_end     = next_idx >= IDX_W'(CHANNELS);
   assign status.hold_valid = hold_vld_ff;
   assign status.slot_free  = !rsp_vld_ff || rsp_tready;

   always_comb begin
      item_mode_in  = item_mode_ff;
      item_chan_in  = item_chan_ff;
      item_pulse_in = item_pulse_ff;
      item_group_in = item_group_ff;
      if (cmd.capture) begin
         item_mode_in  = req_mode;
         item_chan_in  = req_channel;
         item_pulse_in = req_pulse_us;
         item_group_in = req_group;
      end
   end

   always_comb begin
      thr_in = csr_we ? csr_wdata : thr_ff;
   end

   always_comb begin
      desired_vld_in = desired_vld_ff;
      written_vld_in = written_vld_ff;
      if (cmd.set_write && set_ok) begin
         desired_vld_in[set_idx] = 1'b1;
      end
      if (cmd.commit) begin
         written_vld_in[rd_idx] = 1'b1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.sync_start) begin
         idx_in = IDX_W'(item_group_ff);
      end else if (cmd.advance) begin
         idx_in = next_idx;
      end
   end

   always_comb begin
      hold_vld_in   = hold_vld_ff;
      hold_idx_in   = hold_idx_ff;
      hold_count_in = hold_count_ff;
      if (cmd.push && cmd.push_last) begin
         hold_vld_in = 1'b0;
      end
      if (cmd.commit) begin
         hold_vld_in   = 1'b1;
         hold_idx_in   = rd_idx;
         hold_count_in = cur_desired;
      end
   end

   always_comb begin
      rsp_vld_in   = rsp_vld_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.push) begin
         rsp_vld_in   = 1'b1;
         rsp_chan_in  = spuc_pkg::OUT_CHAN_W'(hold_idx_ff);
         rsp_addr_in  = spuc_pkg::ADDR_W'(spuc_pkg::OFF_REG_BASE
                                          + 4 * 32'(hold_idx_ff));
         rsp_count_in = hold_count_ff;
         rsp_last_in  = cmd.push_last;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff         <= CNT_W'(spuc_pkg::THRESHOLD_RESET);
         desired_vld_ff <= '0;
         written_vld_ff <= '0;
         hold_vld_ff    <= 1'b0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         thr_ff         <= thr_in;
         desired_vld_ff <= desired_vld_in;
         written_vld_ff <= written_vld_in;
         hold_vld_ff    <= hold_vld_in;
         rsp_vld_ff     <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_mode_ff  <= item_mode_in;
      item_chan_ff  <= item_chan_in;
      item_pulse_ff <= item_pulse_in;
      item_group_ff <= item_group_in;
      idx_ff        <= idx_in;
      hold_idx_ff   <= hold_idx_in;
      hold_count_ff <= hold_count_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.set_write && set_ok) begin
         desired_mem_ff[set_idx] <= conv_count;
      end
      if (cmd.rd_en) begin
         rd_desired_ff <= desired_mem_ff[rd_idx];
         rd_dvld_ff    <= desired_vld_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         written_mem_ff[rd_idx] <= cur_desired;
      end
      if (cmd.rd_en) begin
         rd_written_ff <= written_mem_ff[rd_idx];
         rd_wvld_ff    <= written_vld_ff[rd_idx];
      end
   end

   assign rsp_tvalid      = rsp_vld_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_reg_address = rsp_addr_ff;
   assign rsp_off_count   = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ----- sv/servo_pwm_update_coalescer_top.sv -----
// Servo PWM update coalescer, top level.
//
// Input stream (req_): one item per handshake. tuser is the mode: 0 sets the
// pulse width of one channel, 1 syncs one round-robin group. A set item turns
// pulse_us into a 12-bit off count and stores it as the desired value.
// A sync item scans the channels of the group in ascending order and, for each
// one whose desired count differs from the last written count by more than
// the threshold, sends one off-register write on the output stream (rsp_);
// tlast marks the final write of the sync item. csr_we loads the threshold.
//
// Sequence: a set item is taken and then decoded. A sync item is taken and
// decoded, then gets one store read and one compare per group member, and
// ends with a flush. A hit is parked until the next hit or the end of the
// scan, so the last write reaches the output register at the flush.
// A new item is taken while a finished write still waits in the output
// register; a stalled receiver holds up the scan only when a parked write has
// to move on, at a further hit or at the flush. Reset empties the output,
// sets the threshold to 5 and makes all desired and written counts read zero.
`timescale 1ns / 1ps

module servo_pwm_update_coalescer_top #(
   parameter int unsigned CHANNELS = spuc_pkg::CHANNELS_DEF,
   parameter int unsigned GROUPS   = spuc_pkg::GROUPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // channel[4:0], pulse_us[20:5], group[22:21], zero[23]
   input  logic [spuc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // mode[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_channel[3:0], reg_address[10:4], off_count[22:11], zero[23]
   output logic [spuc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [spuc_pkg::COUNT_W-1:0]        csr_wdata
);

   localparam int unsigned CH_LO  = 0;
   localparam int unsigned PU_LO  = CH_LO + spuc_pkg::CHAN_FIELD_W;
   localparam int unsigned GR_LO  = PU_LO + spuc_pkg::PULSE_W;
   localparam int unsigned OC_LO  = 0;
   localparam int unsigned RA_LO  = OC_LO + spuc_pkg::OUT_CHAN_W;
   localparam int unsigned CO_LO  = RA_LO + spuc_pkg::ADDR_W;
   localparam int unsigned RSP_USED = CO_LO + spuc_pkg::COUNT_W;

   spuc_pkg::cmd_type    cmd;
   spuc_pkg::status_type status;

   logic [spuc_pkg::OUT_CHAN_W-1:0] rsp_out_channel;
   logic [spuc_pkg::ADDR_W-1:0]     rsp_reg_address;
   logic [spuc_pkg::COUNT_W-1:0]    rsp_off_count;

   spuc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   spuc_datapath #(
      .CHANNELS (CHANNELS),
      .GROUPS   (GROUPS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_tuser),
      .req_channel     (req_tdata[CH_LO +: spuc_pkg::CHAN_FIELD_W]),
      .req_pulse_us    (req_tdata[PU_LO +: spuc_pkg::PULSE_W]),
      .req_group       (req_tdata[GR_LO +: spuc_pkg::GROUP_W]),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .status          (status),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_reg_address (rsp_reg_address),
      .rsp_off_count   (rsp_off_count),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = spuc_pkg::RSP_TDATA_W'({rsp_off_count, rsp_reg_address,
                                              rsp_out_channel});

   // Bits from RSP_USED up are the zero fill.
   if (RSP_USED > spuc_pkg::RSP_TDATA_W) begin : g_width_error
      $error("Output fields overflow rsp_tdata");
   end

endmodule

// ----- sv/spuc_checker.sv -----
// Port checker of the coalescer and its bind to the top level.
`timescale 1ns / 1ps
`include "servo_pwm_update_coalescer_top_defines.svh"

module spuc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [spuc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast
);

   // A stalled write stays offered.
   `SPUC_ASSERT(a_rsp_hold_valid, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp_tvalid dropped while stalled")

   // A stalled write keeps its payload.
   `SPUC_ASSERT(a_rsp_hold_data, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast), "rsp payload changed while stalled")

   // Off register address is 8 plus 4 times the channel.
   `SPUC_ASSERT(a_rsp_address, rsp_tvalid |-> (rsp_tdata[5:4] == 2'b00) && (rsp_tdata[9:6] == 4'(rsp_tdata[3:0] + 4'd2)), "reg_address does not match out_channel")

   // Each item keeps the block busy in the cycle after it is taken.
   `SPUC_ASSERT(a_req_busy, req_tvalid && req_tready |=> !req_tready, "req_tready stayed high after an accept")

   // Reset empties the output register.
   `SPUC_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid, "rsp_tvalid high after reset")

endmodule

bind servo_pwm_update_coalescer_top spuc_checker u_spuc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
